// ===== hw/rtl/entropy_ratio_shock_switch_macros.svh =====
// Assertion macros shared by the entropy shock switch RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ENTROPY_RATIO_SHOCK_SWITCH_MACROS_SVH
`define ENTROPY_RATIO_SHOCK_SWITCH_MACROS_SVH

// Implication checked on each rising clock edge outside reset.
`define ERSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on each rising clock edge outside reset.
`define ERSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/erss_pkg.sv =====
// Package for the entropy shock switch: widths, the log table and shared types.
// Depends on nothing.
package erss_pkg;

  localparam int LogTableBits   = 6;
  localparam int SwitchFracBits = 16;
  localparam int SwitchW        = SwitchFracBits + 1;
  localparam int EntW           = 24;
  localparam int RemW           = 31 - LogTableBits;
  localparam int TabN           = 1 << LogTableBits;
  localparam logic [15:0] Ln2Q16 = 16'd45426;

  typedef logic signed [EntW-1:0] ent_t;

  // Table point computed by the squaring recurrence; evaluated for constants only.
  function automatic logic [16:0] table_point(input int unsigned i);
    logic [63:0] y;
    logic [16:0] r;
    if (i >= TabN) begin
      return 17'd65536;
    end
    y = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
    r = '0;
    for (int n = 0; n < 16; n++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  typedef struct packed {
    logic       start;
    logic [1:0] seen;
  } row_ctl_t;

endpackage

// ===== hw/rtl/erss_if.sv =====
// Valid/ready channel interfaces for the entropy shock switch.
// Depends on erss_pkg.
interface erss_in_if import erss_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] pressure_value;
  logic [31:0] density_value;
  logic [14:0] heat_ratio;
  logic        row_start;
  modport source (output valid, pressure_value, density_value, heat_ratio, row_start,
                  input ready);
  modport sink (input valid, pressure_value, density_value, heat_ratio, row_start,
                output ready);
endinterface

interface erss_out_if import erss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SwitchW-1:0] switch_value;
  modport source (output valid, switch_value, input ready);
  modport sink (input valid, switch_value, output ready);
endinterface

// ===== hw/rtl/entropy_ratio_shock_switch.sv =====
// Top level of the entropy shock switch: sequencer, history and output register.
// Depends on erss_pkg, erss_if, erss_log2, erss_div and the macro header.
// One cell is taken at a time. Both logarithms share one unit whose leading-one search
// steps one bit a cycle, so each runs longer the more bits lie above the leading one of its
// operand. A ghost cell ends once its entropy is scaled; a middle cell, when its ratio
// lies strictly between zero and one, also runs the 16-step bit-serial divider.
// The result sits in an output register while the next cell is already taken; a middle
// cell waits at its division step while that register is still full.
`include "entropy_ratio_shock_switch_macros.svh"
module entropy_ratio_shock_switch import erss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  erss_in_if.sink    in_i,
  erss_out_if.source out_o
);

  typedef enum logic [2:0] {StIdle, StLogP, StLogR, StComb, StScale, StDiv, StWait}
    st_e;

  st_e                   state_q;
  logic [31:0]           rho_q;
  logic [14:0]           gam_q;
  row_ctl_t              ctl_q;
  logic signed [22:0]    lp_q;
  logic signed [47:0]    a_q;
  ent_t                  s_q, older_q, newer_q;
  logic [1:0]            seen_q;
  logic                  ovalid_q;
  logic [SwitchW-1:0]    oval_q;
  logic                  lg_start, lg_done, dv_start, dv_done;
  logic [31:0]           lg_x;
  logic signed [22:0]    lg_y;
  logic [SwitchW-1:0]    dv_q;
  logic signed [EntW:0]  num, den;
  logic [EntW:0]         an, ad;
  logic signed [64:0]    prod;
  logic signed [64:0]    sfl;
  logic                  accept;
  logic                  dv_pend_q;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.switch_value = oval_q;

  assign lg_start = accept || (state_q == StLogP && lg_done);
  assign lg_x     = accept ? in_i.pressure_value : rho_q;

  assign num = $signed({newer_q[EntW-1], newer_q}) - $signed({older_q[EntW-1], older_q});
  assign den = $signed({s_q[EntW-1], s_q}) - $signed({newer_q[EntW-1], newer_q});
  assign an  = num[EntW] ? (EntW+1)'(0) - num : num;
  assign ad  = den[EntW] ? (EntW+1)'(0) - den : den;
  assign dv_start = (state_q == StDiv) && !dv_pend_q && ad > an && num != '0
                    && (num[EntW] == den[EntW]);

  assign prod = 65'(a_q) * $signed(65'(Ln2Q16)) + (65'sd1 <<< 27);
  assign sfl  = prod >>> 28;

  erss_log2 u_log (
    .clk_i, .rst_ni, .start_i(lg_start), .x_i(lg_x), .done_o(lg_done), .log_o(lg_y)
  );

  erss_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(an), .den_i(ad),
    .done_o(dv_done), .quo_o(dv_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      seen_q    <= '0;
      older_q   <= '0;
      newer_q   <= '0;
      ovalid_q  <= 1'b0;
      dv_pend_q <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            rho_q   <= in_i.density_value;
            gam_q   <= in_i.heat_ratio;
            ctl_q   <= '{start: in_i.row_start, seen: seen_q};
            state_q <= StLogP;
          end
        end
        StLogP: if (lg_done) begin
          lp_q    <= lg_y;
          state_q <= StLogR;
        end
        StLogR: if (lg_done) begin
          a_q     <= 48'(lp_q) * 48'sd4096 - $signed({33'd0, gam_q}) * 48'(lg_y);
          state_q <= StComb;
        end
        StComb: state_q <= StScale;
        StScale: begin
          if (sfl > 65'sd8388607) s_q <= ent_t'(24'sh7fffff);
          else if (sfl < -65'sd8388608) s_q <= ent_t'(-24'sh800000);
          else s_q <= ent_t'(sfl);
          state_q <= (ctl_q.start || ctl_q.seen != 2'd2) ? StWait : StDiv;
        end
        StDiv: begin
          if (dv_start) begin
            dv_pend_q <= 1'b1;
          end else if (dv_pend_q) begin
            if (dv_done && !ovalid_q) begin
              oval_q    <= dv_q;
              ovalid_q  <= 1'b1;
              dv_pend_q <= 1'b0;
              state_q   <= StWait;
            end
          end else if (!ovalid_q) begin
            if (den == '0) oval_q <= num[EntW] ? SwitchW'(1) << SwitchFracBits : '0;
            else if (num == '0 || num[EntW] != den[EntW])
              oval_q <= SwitchW'(1) << SwitchFracBits;
            else oval_q <= '0;
            ovalid_q <= 1'b1;
            state_q  <= StWait;
          end
        end
        StWait: begin
          if (ctl_q.start || ctl_q.seen == 2'd0) begin
            older_q <= '0;
            seen_q  <= 2'd1;
          end else begin
            older_q <= newer_q;
            seen_q  <= 2'd2;
          end
          newer_q <= s_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ERSS_ASSERT_IMP(a_ready_idle, in_i.ready, state_q == StIdle, "ready outside idle")
  `ERSS_ASSERT_IMP(a_seen_range, 1'b1, seen_q != 2'd3, "row count out of range")
  `ERSS_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid,
                    "result dropped while stalled")
  `ERSS_ASSERT_IMP(a_div_idle, dv_start, state_q == StDiv, "divider started outside div")

endmodule

// ===== hw/rtl/erss_log2.sv =====
// Log2 unit: leading-one search one bit a cycle, then table interpolation.
// Depends on erss_pkg.
module erss_log2 import erss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  output logic        done_o,
  output logic signed [22:0] log_o
);

  typedef enum logic [1:0] {LgIdle, LgScan, LgMul, LgSum} lg_state_e;

  lg_state_e               state_q;
  logic [31:0]             x_q;
  logic [4:0]              m_q;
  logic [16:0]             t0_q;
  logic [16:0]             dt_q;
  logic [RemW-1:0]         rem_q;
  logic [41:0]             prod_q;
  logic                    done_q;
  logic signed [22:0]      log_q;
  logic [30:0]             f;
  logic [LogTableBits-1:0] idx;

  function automatic logic [16:0] tab(input logic [LogTableBits-1:0] i);
    logic [16:0] r;
    r = '0;
    for (int k = 0; k < TabN; k++) begin
      if (i == LogTableBits'(k)) r = table_point(k);
    end
    return r;
  endfunction

  function automatic logic [16:0] tab_next(input logic [LogTableBits-1:0] i);
    logic [16:0] r;
    r = '0;
    for (int k = 0; k < TabN; k++) begin
      if (i == LogTableBits'(k)) r = table_point(k + 1);
    end
    return r;
  endfunction

  always_comb begin
    f   = x_q[30:0];
    idx = f[30 -: LogTableBits];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LgIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        LgIdle: begin
          if (start_i) begin
            x_q     <= (x_i == '0) ? 32'd1 : x_i;
            m_q     <= 5'd31;
            state_q <= LgScan;
          end
        end
        LgScan: begin
          if (x_q[31] || m_q == '0) begin
            t0_q    <= tab(idx);
            dt_q    <= tab_next(idx);
            rem_q   <= f[RemW-1:0];
            state_q <= LgMul;
          end else begin
            x_q <= x_q << 1;
            m_q <= m_q - 5'd1;
          end
        end
        LgMul: begin
          prod_q  <= 42'(dt_q - t0_q) * 42'(rem_q);
          state_q <= LgSum;
        end
        LgSum: begin
          log_q   <= 23'(($signed({18'd0, m_q}) - 23'sd16) <<< 16)
                   + $signed(23'(t0_q) + 23'(prod_q >> RemW));
          done_q  <= 1'b1;
          state_q <= LgIdle;
        end
        default: state_q <= LgIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign log_o  = log_q;

endmodule

// ===== hw/rtl/erss_div.sv =====
// Bit-serial restoring divider producing the switch fraction.
// Depends on erss_pkg.
module erss_div import erss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [EntW:0]      num_i,
  input  logic [EntW:0]      den_i,
  output logic               done_o,
  output logic [SwitchW-1:0] quo_o
);

  localparam int CntW = $clog2(SwitchFracBits + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [EntW+1:0] rem_q;
  logic [EntW:0]   den_q;
  logic [SwitchFracBits-1:0] q_q;
  logic [EntW+1:0] sh;

  assign sh = {rem_q[EntW:0], 1'b0};

  // The done flag stays high from the last step until the next start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= CntW'(SwitchFracBits);
        rem_q  <= {1'b0, num_i};
        den_q  <= den_i;
        q_q    <= '0;
      end else if (busy_q) begin
        if (sh >= {1'b0, den_q}) begin
          rem_q <= sh - {1'b0, den_q};
          q_q   <= {q_q[SwitchFracBits-2:0], 1'b1};
        end else begin
          rem_q <= sh;
          q_q   <= {q_q[SwitchFracBits-2:0], 1'b0};
        end
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = (SwitchW'(1) << SwitchFracBits) - SwitchW'(q_q);

endmodule

// ===== bench/entropy_ratio_shock_switch_tb.sv =====
// Testbench for entropy_ratio_shock_switch: drives cell requests on the input channel
// and checks each switch value against an in-bench entropy and switch predictor.
// Depends on erss_pkg, erss_if and the block's RTL.
module entropy_ratio_shock_switch_tb;
  import erss_pkg::*;

  typedef struct packed {
    logic [31:0] pressure;
    logic [31:0] density;
    logic [14:0] gamma;
    logic        start;
  } cell_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  erss_in_if  in_ch ();
  erss_out_if out_ch ();

  entropy_ratio_shock_switch DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  cell_t             cell_queue[$];
  logic [SwitchW-1:0] switch_expected[$];
  logic [16:0]       log_points[0:TabN];
  ent_t              ent_older, ent_newer;
  int unsigned       row_fill;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  int unsigned       send_wait, recv_wait;
  bit                feeding_done;
  bit                drain_hold;

  function automatic logic [16:0] point_of(int unsigned i);
    logic [63:0] y;
    logic [16:0] r;
    if (i >= TabN) return 17'd65536;
    y = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
    r = '0;
    for (int n = 0; n < 16; n++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic longint log2_fixed(logic [31:0] x);
    int m;
    logic [31:0] f;
    longint unsigned idx, rem, t0, t1;
    if (x == 0) x = 1;
    m = 31;
    while (m > 0 && !x[m]) m--;
    f = (x << (31 - m)) & 32'h7FFF_FFFF;
    idx = f >> RemW;
    rem = f & ((32'd1 << RemW) - 1);
    t0 = log_points[idx];
    t1 = log_points[idx + 1];
    return longint'(m - 16) * 65536 + longint'(t0 + (((t1 - t0) * rem) >> RemW));
  endfunction

  function automatic ent_t entropy_of(cell_t c);
    longint a, prod, s;
    a = log2_fixed(c.pressure) * 4096 - longint'(c.gamma) * log2_fixed(c.density);
    prod = a * 45426 + (longint'(1) << 27);
    if (prod >= 0) s = prod >>> 28;
    else s = -((-prod + ((longint'(1) << 28) - 1)) >>> 28);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return ent_t'(s);
  endfunction

  function automatic logic [SwitchW-1:0] switch_of(ent_t prev, ent_t mid, ent_t nxt);
    longint num, den, an, ad, one;
    one = longint'(1) << SwitchFracBits;
    num = longint'(mid) - longint'(prev);
    den = longint'(nxt) - longint'(mid);
    if (den == 0) return (num < 0) ? SwitchW'(one) : '0;
    if (num == 0 || ((num < 0) != (den < 0))) return SwitchW'(one);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    if (an >= ad) return '0;
    return SwitchW'(one - (an * one) / ad);
  endfunction

  function automatic void predict_cell(cell_t c);
    ent_t s;
    s = entropy_of(c);
    if (c.start || row_fill == 0) begin
      ent_older = '0;
      row_fill = 1;
    end else if (row_fill == 1) begin
      ent_older = ent_newer;
      row_fill = 2;
    end else begin
      switch_expected.push_back(switch_of(ent_older, ent_newer, s));
      ent_older = ent_newer;
    end
    ent_newer = s;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return 32'h0001_0000 + $urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell(bit start);
    cell_t c;
    c.pressure = rand_value();
    c.density = rand_value();
    c.gamma = ($urandom_range(0, 19) == 0) ? 15'($urandom) : 15'($urandom_range(4096, 16384));
    c.start = start;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.pressure_value <= '0;
      in_ch.density_value <= '0;
      in_ch.heat_ratio <= '0;
      in_ch.row_start <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_cell({in_ch.pressure_value,
          in_ch.density_value, in_ch.heat_ratio, in_ch.row_start});
      if (!in_ch.valid || in_ch.ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (cell_queue.size() != 0 && !drain_hold) begin
          cell_t c;
          c = cell_queue.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.pressure_value, in_ch.density_value, in_ch.heat_ratio,
           in_ch.row_start} <= c;
          send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (switch_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected switch value %0d", out_ch.switch_value));
        end else begin
          logic [SwitchW-1:0] want;
          want = switch_expected.pop_front();
          if (out_ch.switch_value !== want)
            report_mismatch($sformatf("switch value %0d, expected %0d",
                                      out_ch.switch_value, want));
        end
        recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cell_t c;
    int row_len;
    for (int i = 0; i <= TabN; i++) log_points[i] = point_of(i);
    ent_older = '0;
    ent_newer = '0;
    row_fill = 0;
    mismatches = 0;
    cycle_count = 0;
    drain_hold = 1'b0;
    // Cells ahead of any row start, then field extremes and special ratios.
    cell_queue.push_back('{32'h0001_0000, 32'h0001_0000, 15'd5734, 1'b0});
    cell_queue.push_back('{32'h0002_0000, 32'h0001_0000, 15'd5734, 1'b0});
    cell_queue.push_back('{32'h0004_0000, 32'h0001_0000, 15'd5734, 1'b0});
    cell_queue.push_back('{32'h0004_0000, 32'h0001_0000, 15'd5734, 1'b0});
    cell_queue.push_back('{32'h0001_0000, 32'h0001_0000, 15'd5734, 1'b0});
    cell_queue.push_back('{32'd0, 32'hFFFF_FFFF, 15'd16384, 1'b1});
    cell_queue.push_back('{32'hFFFF_FFFF, 32'd0, 15'd16384, 1'b0});
    cell_queue.push_back('{32'd0, 32'd0, 15'd4096, 1'b0});
    cell_queue.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF, 1'b0});
    cell_queue.push_back('{32'd0, 32'hFFFF_FFFF, 15'h7FFF, 1'b0});
    cell_queue.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 15'h2AAA, 1'b1});
    cell_queue.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 15'h5555, 1'b0});
    cell_queue.push_back('{32'h0003_0000, 32'h0001_0000, 15'd0, 1'b0});
    cell_queue.push_back('{32'h0003_0000, 32'h0001_0000, 15'd0, 1'b1});
    cell_queue.push_back('{32'h0001_0000, 32'h0002_0000, 15'd4096, 1'b1});
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (cell_queue.size() != 0) @(posedge clk_i);
    drain_hold <= 1'b1;
    while (switch_expected.size() != 0 || in_ch.valid) @(posedge clk_i);
    drain_hold <= 1'b0;
    for (int n = 0; n < 500; n += row_len) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      for (int k = 0; k < row_len; k++) begin
        c = rand_cell(k == 0 ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 40) == 0));
        if (k != 0 && $urandom_range(0, 3) == 0) begin
          c.pressure = cell_queue[$].pressure + $urandom_range(0, 3);
          c.density = cell_queue[$].density;
          c.gamma = cell_queue[$].gamma;
        end
        cell_queue.push_back(c);
      end
    end
    while (cell_queue.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (switch_expected.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && switch_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
